[sv/gdc_pkg.sv]
package gdc_pkg;

  // Vertex id and degree store geometry
  localparam int unsigned VERTEX_BITS = 16;
  localparam int unsigned VERTICES    = 1 << VERTEX_BITS;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned VCOUNT_BITS = VERTEX_BITS + 1;

  // Item opcodes
  localparam logic [1:0] OP_HEADER   = 2'd0;
  localparam logic [1:0] OP_NEIGHBOR = 2'd1;
  localparam logic [1:0] OP_READOUT  = 2'd2;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [VERTEX_BITS-1:0] vertex;
  } gdc_in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  in_count;
    logic [COUNT_BITS-1:0]  out_count;
    logic [VCOUNT_BITS-1:0] vertex_count;
    logic [COUNT_BITS-1:0]  edge_count;
    logic                   beyond_count;
  } gdc_out_t;

  // Control of one degree store
  typedef struct packed {
    logic                   clear;
    logic                   read;
    logic                   bump;
    logic [VERTEX_BITS-1:0] addr;
  } gdc_ram_ctrl_t;

  // Add one, stop at all ones
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

[sv/gdc_degree_ram.sv]
module gdc_degree_ram
  import gdc_pkg::*;
(
  input  logic                  clk_i,
  input  gdc_ram_ctrl_t         ctrl_i,
  output logic [COUNT_BITS-1:0] count_o
);

  logic [COUNT_BITS-1:0]  mem_q [VERTICES];
  logic [COUNT_BITS-1:0]  rd_q;
  logic [VERTEX_BITS-1:0] addr_q;

  // Write port: clear sweep, or write back the bumped count to the last read entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      mem_q[ctrl_i.addr] <= '0;
    end else if (ctrl_i.bump) begin
      mem_q[addr_q] <= sat_inc(rd_q);
    end
  end

  // Read port: registered data, remember the address for the write back
  always_ff @(posedge clk_i) begin
    if (ctrl_i.read) begin
      rd_q   <= mem_q[ctrl_i.addr];
      addr_q <= ctrl_i.addr;
    end
  end

  assign count_o = rd_q;

endmodule

[sv/graph_degree_counter_core.sv]
// Vertex degree counter over an adjacency-list stream. An item is taken when
// start is high and busy is low. Header items, self-loop neighbors and unused
// opcodes need no modify step; neighbor items that form an edge and readout
// items also pass a modify step, with busy high, since each reads its degree
// entries from the registered read port of each store and writes back or
// reports in that step. A readout result is on result_o with result_valid_o
// high for exactly one cycle, registered from the store data in the modify
// step; the receiver cannot stall it. After reset busy stays high while both
// degree stores are swept to zero, one entry per cycle, over all 65536 entries.
module graph_degree_counter_core
  import gdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  gdc_in_t  item_i,
  output logic     busy,
  output logic     result_valid_o,
  output gdc_out_t result_o
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_MODIFY = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [VERTEX_BITS-1:0] clr_q, clr_d;
  logic [VERTEX_BITS-1:0] src_q, src_d;
  logic [VERTEX_BITS-1:0] high_q, high_d;
  logic [COUNT_BITS-1:0]  edge_q, edge_d;
  logic [1:0]             op_q;
  logic [VERTEX_BITS-1:0] vertex_q;
  logic                   valid_q, valid_d;
  gdc_out_t               result_q, result_d;

  logic                   accept;
  logic                   is_edge;
  logic                   is_read;
  logic [VCOUNT_BITS-1:0] vcount;
  gdc_ram_ctrl_t          in_ctrl, out_ctrl;
  logic [COUNT_BITS-1:0]  in_rd, out_rd;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign is_edge = (item_i.opcode == OP_NEIGHBOR) && (item_i.vertex != src_q);
  assign is_read = (item_i.opcode == OP_READOUT);
  assign vcount  = {1'b0, high_q} + VCOUNT_BITS'(1);

  // Degree store control: clear sweep, read on an accepted edge or readout, write back in modify
  always_comb begin
    in_ctrl.clear  = (state_q == ST_CLEAR);
    in_ctrl.read   = accept && (is_edge || is_read);
    in_ctrl.bump   = (state_q == ST_MODIFY) && (op_q == OP_NEIGHBOR);
    in_ctrl.addr   = in_ctrl.clear ? clr_q : item_i.vertex;
    out_ctrl.clear = in_ctrl.clear;
    out_ctrl.read  = in_ctrl.read;
    out_ctrl.bump  = in_ctrl.bump;
    if (out_ctrl.clear) begin
      out_ctrl.addr = clr_q;
    end else if (is_read) begin
      out_ctrl.addr = item_i.vertex;
    end else begin
      out_ctrl.addr = src_q;
    end
  end

  gdc_degree_ram u_in_ram (
    .clk_i   (clk_i),
    .ctrl_i  (in_ctrl),
    .count_o (in_rd)
  );

  gdc_degree_ram u_out_ram (
    .clk_i   (clk_i),
    .ctrl_i  (out_ctrl),
    .count_o (out_rd)
  );

  // Sequencer and scalar state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    src_d   = src_q;
    high_d  = high_q;
    edge_d  = edge_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + VERTEX_BITS'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (item_i.opcode == OP_HEADER) begin
            src_d = item_i.vertex;
            if (item_i.vertex > high_q) begin
              high_d = item_i.vertex;
            end
          end
          if (is_edge) begin
            edge_d = sat_inc(edge_q);
          end
          if (is_edge || is_read) begin
            state_d = ST_MODIFY;
          end
        end
      end
      ST_MODIFY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Build the readout beat from the registered store data
  always_comb begin
    valid_d               = (state_q == ST_MODIFY) && (op_q == OP_READOUT);
    result_d              = result_q;
    if (valid_d) begin
      result_d.in_count     = in_rd;
      result_d.out_count    = out_rd;
      result_d.vertex_count = vcount;
      result_d.edge_count   = edge_q;
      result_d.beyond_count = ({1'b0, vertex_q} >= vcount);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      src_q   <= '0;
      high_q  <= '0;
      edge_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      src_q   <= src_d;
      high_q  <= high_d;
      edge_q  <= edge_d;
      valid_q <= valid_d;
    end
  end

  // Hold the item and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= item_i.opcode;
      vertex_q <= item_i.vertex;
    end
    result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  // A result beat follows only a readout in the modify step
  a_result_from_readout : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($past(state_q) == ST_MODIFY) && ($past(op_q) == OP_READOUT))
    else $error("result beat without a readout");

  // The modify step is followed by idle and leaves the block free again
  a_modify_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY) |=> (state_q == ST_IDLE))
    else $error("modify step did not return to idle");

  // Edge total and highest vertex never decrease
  a_edge_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (edge_q >= $past(edge_q)) && (high_q >= $past(high_q)))
    else $error("edge total or highest vertex decreased");

  // No store read or write back while the clear sweep runs
  a_no_bump_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ctrl.bump && !in_ctrl.read)
    else $error("store access during clear sweep");

endmodule

[verif/graph_degree_counter_core_test.sv]
module graph_degree_counter_core_test
  import gdc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned ITEM_TARGET  = 1700;
  localparam int unsigned QUIET_TAIL   = 200;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    gdc_in_t     beat;
    int unsigned gap;
    bit          drain;
  } pending_beat_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  gdc_in_t  item = '0;
  logic     busy;
  logic     result_valid;
  gdc_out_t result;

  // Beats still to send, and readouts whose result has not come yet
  pending_beat_t item_backlog[$];
  gdc_out_t      readout_due[$];

  // Own copy of the graph counters
  bit [COUNT_BITS-1:0]  in_deg [VERTICES];
  bit [COUNT_BITS-1:0]  out_deg [VERTICES];
  bit [VERTEX_BITS-1:0] cur_source;
  bit [VERTEX_BITS-1:0] top_vertex;
  bit [COUNT_BITS-1:0]  edge_sum;

  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned idle_run;
  int unsigned cycles;
  int unsigned errors;
  bit          bursty;

  graph_degree_counter_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item),
    .busy           (busy),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Add one, hold at all ones
  function automatic bit [COUNT_BITS-1:0] count_up(input bit [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Update the graph counters with one accepted beat; queue the readout result
  function automatic void apply_to_graph(input gdc_in_t beat);
    gdc_out_t                  res;
    logic [VCOUNT_BITS-1:0]    nverts;
    case (beat.opcode)
      OP_HEADER: begin
        cur_source = beat.vertex;
        if (beat.vertex > top_vertex) top_vertex = beat.vertex;
      end
      OP_NEIGHBOR: begin
        // skip self loops
        if (beat.vertex != cur_source) begin
          edge_sum = count_up(edge_sum);
          out_deg[cur_source] = count_up(out_deg[cur_source]);
          in_deg[beat.vertex] = count_up(in_deg[beat.vertex]);
        end
      end
      OP_READOUT: begin
        nverts = VCOUNT_BITS'(top_vertex) + VCOUNT_BITS'(1);
        res.in_count     = in_deg[beat.vertex];
        res.out_count    = out_deg[beat.vertex];
        res.vertex_count = nverts;
        res.edge_count   = edge_sum;
        res.beyond_count = (VCOUNT_BITS'(beat.vertex) >= nverts);
        readout_due.insert(readout_due.size(), res);
      end
      default: begin
      end
    endcase
  endfunction

  // Append one beat; gap drawn from the current idling mode
  function automatic void queue_item(input logic [1:0] op, input logic [VERTEX_BITS-1:0] v,
                                     input bit drain);
    pending_beat_t pb;
    pb.beat.opcode = op;
    pb.beat.vertex = v;
    pb.drain = drain;
    pb.gap = (bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    item_backlog.insert(item_backlog.size(), pb);
    if (op != OP_UNUSED) items_queued++;
  endfunction

  // Mostly a small pool so degrees pile up; sometimes anything
  function automatic logic [VERTEX_BITS-1:0] pick_vertex(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return VERTEX_BITS'($urandom_range(0, 63));
    if (r < 80) return VERTEX_BITS'($urandom_range(0, span));
    if (r < 95) return VERTEX_BITS'($urandom());
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // Drive beats: hold start until taken, then load the next one
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    logic          taken;
    pending_beat_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      item <= '0;
      idle_run = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        apply_to_graph(item);
        items_taken++;
      end
      if (!start || taken) begin
        if (item_backlog.size() == 0) begin
          start <= 1'b0;
        end else if (item_backlog[0].drain && readout_due.size() != 0) begin
          start <= 1'b0;
        end else if (idle_run < item_backlog[0].gap) begin
          idle_run++;
          start <= 1'b0;
        end else begin
          nxt = item_backlog.pop_front();
          idle_run = 0;
          start <= 1'b1;
          item <= nxt.beat;
        end
      end
    end
  end

  // Check each readout beat against the oldest expectation
  always @(posedge clk_i) begin : check_results
    gdc_out_t want;
    if (rst_ni && result_valid) begin
      if (readout_due.size() == 0) begin
        $error("unexpected readout beat: in_count %0d out_count %0d", result.in_count,
               result.out_count);
        errors++;
      end else begin
        want = readout_due.pop_front();
        if (result.in_count !== want.in_count) begin
          $error("in_count: expected %0d, got %0d", want.in_count, result.in_count);
          errors++;
        end
        if (result.out_count !== want.out_count) begin
          $error("out_count: expected %0d, got %0d", want.out_count, result.out_count);
          errors++;
        end
        if (result.vertex_count !== want.vertex_count) begin
          $error("vertex_count: expected %0d, got %0d", want.vertex_count,
                 result.vertex_count);
          errors++;
        end
        if (result.edge_count !== want.edge_count) begin
          $error("edge_count: expected %0d, got %0d", want.edge_count, result.edge_count);
          errors++;
        end
        if (result.beyond_count !== want.beyond_count) begin
          $error("beyond_count: expected %0b, got %0b", want.beyond_count,
                 result.beyond_count);
          errors++;
        end
      end
    end
  end

  // Stop a hung run; the limit covers the clearing sweep after reset
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VERTEX_BITS-1:0] src;
    int unsigned            span;
    int unsigned            seq;
    int unsigned            n;
    bit                     drain;
    logic [VERTEX_BITS-1:0] tgt;

    bursty = 1'b1;

    // Directed: empty graph, neighbor before any header, self loops,
    // unused opcode, unseen vertices on both sides of the vertex count
    queue_item(OP_READOUT, 16'd0, 1'b0);
    queue_item(OP_READOUT, 16'hFFFF, 1'b0);
    queue_item(OP_NEIGHBOR, 16'd5, 1'b0);
    queue_item(OP_NEIGHBOR, 16'd0, 1'b0);
    queue_item(OP_HEADER, 16'd300, 1'b0);
    queue_item(OP_NEIGHBOR, 16'd300, 1'b0);
    queue_item(OP_NEIGHBOR, 16'hFFFF, 1'b0);
    queue_item(OP_NEIGHBOR, 16'd5, 1'b0);
    queue_item(OP_UNUSED, 16'hFFFF, 1'b0);
    queue_item(OP_UNUSED, 16'd0, 1'b0);
    queue_item(OP_READOUT, 16'd5, 1'b0);
    queue_item(OP_READOUT, 16'd0, 1'b0);
    queue_item(OP_READOUT, 16'd300, 1'b0);
    queue_item(OP_READOUT, 16'hFFFF, 1'b0);
    queue_item(OP_READOUT, 16'd301, 1'b0);
    queue_item(OP_HEADER, 16'd7, 1'b0);
    queue_item(OP_NEIGHBOR, 16'd300, 1'b0);
    queue_item(OP_NEIGHBOR, 16'd7, 1'b0);
    queue_item(OP_READOUT, 16'd7, 1'b0);
    queue_item(OP_READOUT, 16'd300, 1'b0);
    queue_item(OP_READOUT, 16'd299, 1'b0);

    // Random adjacency lists; the vertex range widens as the run goes on
    seq = 0;
    while (items_queued < ITEM_TARGET) begin
      span = (64 + items_queued * 40 > 65535) ? 65535 : 64 + items_queued * 40;
      bursty = (items_queued + QUIET_TAIL < ITEM_TARGET) && ($urandom_range(0, 2) != 0);
      drain = (seq % 40 == 0);
      seq++;
      if ($urandom_range(0, 9) != 0) begin
        src = ($urandom_range(0, 99) < 85) ? VERTEX_BITS'($urandom_range(0, 63))
                                           : VERTEX_BITS'($urandom_range(0, span));
        queue_item(OP_HEADER, src, drain);
        n = $urandom_range(0, 8);
        repeat (n) begin
          tgt = ($urandom_range(0, 99) < 15) ? src : pick_vertex(span);
          queue_item(OP_NEIGHBOR, tgt, 1'b0);
          if ($urandom_range(0, 4) == 0) queue_item(OP_READOUT, pick_vertex(span), 1'b0);
        end
        queue_item(OP_READOUT, ($urandom_range(0, 1) != 0) ? src : pick_vertex(span), 1'b0);
      end else begin
        // noise: ignored opcode, stray neighbor or lone readout
        case ($urandom_range(0, 2))
          0: queue_item(OP_UNUSED, VERTEX_BITS'($urandom()), drain);
          1: queue_item(OP_NEIGHBOR, pick_vertex(span), drain);
          default: queue_item(OP_READOUT, pick_vertex(span), drain);
        endcase
      end
    end

    // Largest source last, so earlier readouts can still land beyond the count
    bursty = 1'b0;
    queue_item(OP_HEADER, 16'hFFFF, 1'b1);
    queue_item(OP_NEIGHBOR, 16'd0, 1'b0);
    queue_item(OP_NEIGHBOR, 16'hFFFF, 1'b0);
    queue_item(OP_READOUT, 16'hFFFF, 1'b0);
    queue_item(OP_READOUT, 16'd0, 1'b0);
    queue_item(OP_READOUT, VERTEX_BITS'($urandom()), 1'b0);

    // Hold reset low, then release it on a clock edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to be taken and every readout to come back
    while (items_taken < items_queued + (item_backlog.size() == 0 ? 0 : 1) ||
           item_backlog.size() != 0 || start)
      @(posedge clk_i);
    while (readout_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/gdc_pkg.sv
sv/gdc_degree_ram.sv
sv/graph_degree_counter_core.sv
verif/graph_degree_counter_core_test.sv
